@@ hw/rtl/raw_profile_hex_decoder_macros.svh @@
`ifndef RAW_PROFILE_HEX_DECODER_MACROS_SVH
`define RAW_PROFILE_HEX_DECODER_MACROS_SVH

// a true in a cycle implies b in the same cycle
`define RPHD_ASSERT_NOW(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// a true in a cycle implies b in the next cycle
`define RPHD_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

@@ hw/rtl/rphd_pkg.sv @@
`timescale 1ns / 1ps

package rphd_pkg;

	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_NL      = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_LOW_A   = 8'h61;
	localparam logic [7:0] CHAR_LOW_F   = 8'h66;
	localparam logic [3:0] HEX_TEN      = 4'd10;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [2:0] {
		PH_SKIP0,
		PH_SEEK_NL,
		PH_BLANK,
		PH_DIGITS,
		PH_DECODE,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       status;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h = '0;
		if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
			h.ok    = 1'b1;
			h.value = b[3:0];
		end else if (b >= CHAR_LOW_A && b <= CHAR_LOW_F) begin
			h.ok    = 1'b1;
			h.value = b[3:0] - 4'd1 + HEX_TEN;
		end
		return h;
	endfunction

endpackage

@@ hw/rtl/rphd_in_if.sv @@
`timescale 1ns / 1ps

interface rphd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ hw/rtl/rphd_out_if.sv @@
`timescale 1ns / 1ps

interface rphd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       status;

	modport source (output valid, output out_byte, output out_last, output status,
		input ready);
	modport sink (input valid, input out_byte, input out_last, input status,
		output ready);
endinterface

@@ hw/rtl/rphd_front.sv @@
`timescale 1ns / 1ps

module rphd_front import rphd_pkg::*; #(
	parameter int MAX_LENGTH = 65536
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   take,
	input  logic [7:0] in_byte,
	input  logic   in_last,
	output push_t  push
);

	localparam int LEN_W = $clog2(MAX_LENGTH + 2);
	localparam int ACC_W = LEN_W + 4;
	localparam logic [ACC_W-1:0] MAX_ACC = ACC_W'(MAX_LENGTH);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LENGTH);
	localparam logic [LEN_W-1:0] SAT_LEN = LEN_W'(MAX_LENGTH + 1);

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic [3:0]       hi_q, hi_d;
	logic             pend_q, pend_d;

	logic             is_digit, is_blank;
	logic [ACC_W-1:0] acc;
	logic [LEN_W-1:0] cnt_inc;
	hex_t             hex;
	res_t             err_res;

	assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
	assign is_blank = (in_byte == CHAR_NUL) || (in_byte == CHAR_SPACE) || (in_byte == CHAR_NL);
	assign acc = ACC_W'({len_q, 3'b000}) + ACC_W'({len_q, 1'b0}) + ACC_W'(in_byte[3:0]);
	assign cnt_inc = cnt_q + LEN_W'(1);
	assign hex = hex_decode(in_byte);
	assign err_res = '{data: 8'h00, last: 1'b1, status: STATUS_ERR};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP0;
			len_q   <= '0;
			cnt_q   <= '0;
			hi_q    <= '0;
			pend_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			hi_q    <= hi_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		hi_d    = hi_q;
		pend_d  = pend_q;
		push    = '0;
		// a beat marked last always ends the text, also while draining
		case (phase_q)
			PH_SKIP0: begin
				if (in_last) begin
					push.valid = 1'b1;
					push.res   = err_res;
				end else begin
					phase_d = PH_SEEK_NL;
				end
			end
			PH_SEEK_NL: begin
				if (in_last) begin
					push.valid = 1'b1;
					push.res   = err_res;
				end else if (in_byte == CHAR_NL) begin
					phase_d = PH_BLANK;
				end
			end
			PH_BLANK, PH_DIGITS: begin
				if (in_last) begin
					push.valid = 1'b1;
					push.res   = err_res;
				end else if (phase_q == PH_BLANK && is_blank) begin
					phase_d = PH_BLANK;
				end else if (is_digit) begin
					phase_d = PH_DIGITS;
					len_d   = (acc > MAX_ACC) ? SAT_LEN : acc[LEN_W-1:0];
				end else if (len_q == '0 || len_q > MAX_LEN) begin
					push.valid = 1'b1;
					push.res   = err_res;
					phase_d    = PH_DRAIN;
				end else begin
					// drop the separator byte
					phase_d = PH_DECODE;
				end
			end
			PH_DECODE: begin
				if (in_byte == CHAR_NUL) begin
					push.valid = 1'b1;
					push.res   = err_res;
					phase_d    = PH_DRAIN;
				end else if (hex.ok && pend_q) begin
					pend_d     = 1'b0;
					cnt_d      = cnt_inc;
					push.valid = 1'b1;
					if (cnt_inc >= len_q) begin
						push.res = '{data: {hi_q, hex.value}, last: 1'b1, status: STATUS_OK};
						phase_d  = PH_DRAIN;
					end else if (in_last) begin
						push.res = err_res;
					end else begin
						push.res = '{data: {hi_q, hex.value}, last: 1'b0, status: STATUS_OK};
					end
				end else begin
					if (hex.ok) begin
						hi_d   = hex.value;
						pend_d = 1'b1;
					end
					if (in_last) begin
						push.valid = 1'b1;
						push.res   = err_res;
					end
				end
			end
			PH_DRAIN: begin
			end
			default: begin
				phase_d = PH_SKIP0;
			end
		endcase
		// start over on a new text after the final beat
		if (in_last) begin
			phase_d = PH_SKIP0;
			len_d   = '0;
			cnt_d   = '0;
			hi_d    = '0;
			pend_d  = 1'b0;
		end
		// no beat taken, no result
		if (!take) begin
			push = '0;
		end
	end

endmodule

@@ hw/rtl/rphd_queue.sv @@
`timescale 1ns / 1ps

module rphd_queue import rphd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	output qstat_t        qstat,
	rphd_out_if.source    result
);

	res_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;
	res_t       head;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign do_push = push.valid && !qstat.full;
	assign do_pop  = result.ready && !qstat.empty;

	assign head            = mem_q[rd_ptr_q];
	assign result.valid    = !qstat.empty;
	assign result.out_byte = head.data;
	assign result.out_last = head.last;
	assign result.status   = head.status;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/raw_profile_hex_decoder.sv @@
`timescale 1ns / 1ps

// Raw profile hex text decoder.
// feed carries the profile text, one byte per beat, in_last on the final byte.
// result carries decoded data bytes; out_last marks the final byte of a
// profile, and status = 1 marks a malformed text (one beat, out_byte zero,
// out_last set). After a result that ends the profile, the rest of the text
// is swallowed up to its last byte, then the next text starts.
// Throughput: one byte per cycle while feed.ready is high. The parser updates
// its phase in the cycle the byte is taken; its result is written into the
// queue, so result.valid is set in the cycle after the byte's beat.
// A two-entry result queue sits between parser and output: feed.ready drops
// only while both entries hold results the receiver has not taken, so a
// stalled receiver stalls the input after two results at most.
// Reset (arst_n low) returns the parser to the start of a text and empties
// the queue; nothing is pending afterward.
// MAX_LENGTH bounds the declared length; the counters are sized from it.

`include "raw_profile_hex_decoder_macros.svh"

module raw_profile_hex_decoder import rphd_pkg::*; #(
	parameter int MAX_LENGTH = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	rphd_in_if.sink    feed,
	rphd_out_if.source result
);

	push_t  push;
	qstat_t qstat;
	logic   take;

	assign feed.ready = !qstat.full;
	assign take = feed.valid && feed.ready;

	rphd_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.in_byte(feed.in_byte),
		.in_last(feed.in_last),
		.push(push)
	);

	rphd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.qstat(qstat),
		.result(result)
	);

	`RPHD_ASSERT_NOW(a_err_is_last, clk, arst_n, result.valid && result.status, result.out_last, "error beat without out_last")
	`RPHD_ASSERT_NOW(a_err_zero, clk, arst_n, result.valid && result.status, result.out_byte == 8'h00, "error beat with nonzero data")
	`RPHD_ASSERT_NOW(a_push_room, clk, arst_n, push.valid && feed.valid, feed.ready, "result produced into a full queue")
	`RPHD_ASSERT_NEXT(a_push_shows, clk, arst_n, take && push.valid, result.valid, "result did not reach output")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import rphd_pkg::*;

	localparam int MAX_LEN = 65536;
	localparam int N_ITEMS = 800;
	localparam int IDLE_PCT = 29;

	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n;
	int   cyc = 0;
	int   n_fail = 0;
	logic calm;

	beat_t text_q[$];
	res_t  decoded_q[$];

	// text decoder state
	phase_t      txt_phase = PH_SKIP0;
	int unsigned decl_len = 0;
	int unsigned n_decoded = 0;
	logic [3:0]  hi_nib = '0;
	logic        nib_held = 1'b0;

	rphd_in_if  feed_if();
	rphd_out_if res_if();

	raw_profile_hex_decoder #(.MAX_LENGTH(MAX_LEN)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_if.sink),
		.result (res_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CHAR_ZERO && b <= CHAR_NINE;
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || (b >= CHAR_LOW_A && b <= CHAR_LOW_F);
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_hex(c) || c == CHAR_NUL || c == CHAR_SPACE || c == CHAR_NL);
		return c;
	endfunction

	task automatic restart_text();
		txt_phase = PH_SKIP0;
		decl_len  = 0;
		n_decoded = 0;
		hi_nib    = '0;
		nib_held  = 1'b0;
	endtask

	// emit one result: error or data, then drain or start over
	task automatic close_text(input logic lst, input logic [7:0] d, input logic st,
			output logic got, output res_t r);
		got      = 1'b1;
		r.data   = d;
		r.last   = 1'b1;
		r.status = st;
		if (lst) begin
			restart_text();
		end else begin
			txt_phase = PH_DRAIN;
		end
	endtask

	task automatic text_step(input logic [7:0] b, input logic lst,
			output logic got, output res_t r);
		logic [3:0]  nv;
		logic [7:0]  d;
		int unsigned n;
		got = 1'b0;
		r   = '0;
		case (txt_phase)
			PH_SKIP0: begin
				if (lst) begin
					close_text(1'b1, 8'h00, STATUS_ERR, got, r);
				end else begin
					txt_phase = PH_SEEK_NL;
				end
			end
			PH_SEEK_NL: begin
				if (lst) begin
					close_text(1'b1, 8'h00, STATUS_ERR, got, r);
				end else if (b == CHAR_NL) begin
					txt_phase = PH_BLANK;
				end
			end
			PH_BLANK, PH_DIGITS: begin
				if (lst) begin
					close_text(1'b1, 8'h00, STATUS_ERR, got, r);
					return;
				end
				if (txt_phase == PH_BLANK) begin
					if (b == CHAR_NUL || b == CHAR_SPACE || b == CHAR_NL)
						return;
					txt_phase = PH_DIGITS;
				end
				if (is_digit(b)) begin
					n = decl_len * 10 + (b - CHAR_ZERO);
					decl_len = (n > MAX_LEN) ? MAX_LEN + 1 : n;
				end else if (decl_len == 0 || decl_len > MAX_LEN) begin
					close_text(1'b0, 8'h00, STATUS_ERR, got, r);
				end else begin
					txt_phase = PH_DECODE;
				end
			end
			PH_DECODE: begin
				if (b == CHAR_NUL) begin
					close_text(lst, 8'h00, STATUS_ERR, got, r);
					return;
				end
				if (is_hex(b)) begin
					nv = 4'(is_digit(b) ? b - CHAR_ZERO : b - CHAR_LOW_A + HEX_TEN);
					if (!nib_held) begin
						hi_nib   = nv;
						nib_held = 1'b1;
					end else begin
						d         = {hi_nib, nv};
						nib_held  = 1'b0;
						n_decoded = n_decoded + 1;
						if (n_decoded >= decl_len) begin
							close_text(lst, d, STATUS_OK, got, r);
						end else if (lst) begin
							// short text: the error replaces the data byte
							close_text(1'b1, 8'h00, STATUS_ERR, got, r);
						end else begin
							got      = 1'b1;
							r.data   = d;
							r.last   = 1'b0;
							r.status = STATUS_OK;
						end
						return;
					end
				end
				if (lst)
					close_text(1'b1, 8'h00, STATUS_ERR, got, r);
			end
			default: begin
				if (lst)
					restart_text();
			end
		endcase
	endtask

	task automatic push_beat(input logic [7:0] b, input logic l);
		text_q.push_back('{b: b, l: l});
	endtask

	task automatic push_str(input string s);
		for (int k = 0; k < s.len(); k++)
			push_beat(s[k], 1'b0);
	endtask

	// one random profile text, mostly well formed
	task automatic gen_text();
		logic [7:0] t[$];
		logic [7:0] c;
		string      digits;
		int         sel;
		int         len;
		int         body_start;
		int         keep;
		t.push_back(8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 4)) begin
			c = 8'($urandom_range(0, 255));
			if (c == CHAR_NL)
				c = c ^ 8'h01;
			t.push_back(c);
		end
		t.push_back(CHAR_NL);
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 2))
				0: t.push_back(CHAR_NUL);
				1: t.push_back(CHAR_SPACE);
				default: t.push_back(CHAR_NL);
			endcase
		end
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			len    = 0;
			digits = (sel < 4) ? "" : "0";
		end else if (sel < 12) begin
			case ($urandom_range(0, 3))
				0: len = MAX_LEN;
				1: len = MAX_LEN + 1;
				2: len = 99999;
				default: len = 123456789;
			endcase
			digits = $sformatf("%0d", len);
		end else begin
			len    = $urandom_range(1, 12);
			digits = (sel < 30) ? $sformatf("0%0d", len) : $sformatf("%0d", len);
		end
		for (int k = 0; k < digits.len(); k++)
			t.push_back(digits[k]);
		t.push_back((digits.len() > 0 && $urandom_range(0, 1)) ? CHAR_NL : noise_byte());
		body_start = t.size();
		for (int k = 0; k < ((len > 20) ? 20 : len); k++) begin
			repeat (2) begin
				if ($urandom_range(0, 5) == 0)
					t.push_back($urandom_range(0, 1) ? CHAR_NL : noise_byte());
				c = 8'($urandom_range(0, 15));
				t.push_back((c < 8'd10) ? 8'(CHAR_ZERO + c) : 8'(CHAR_LOW_A + c - 8'd10));
			end
		end
		repeat ($urandom_range(0, 3))
			t.push_back(8'($urandom_range(0, 255)));
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			keep = $urandom_range(1, t.size());
			t    = t[0:keep-1];
		end else if (sel < 18 && t.size() > body_start) begin
			t[$urandom_range(body_start, t.size() - 1)] = CHAR_NUL;
		end
		foreach (t[k])
			push_beat(t[k], k == t.size() - 1);
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// long stretch with both sides always active
	assign calm = cyc >= 200 && cyc < 500;

	always @(posedge clk or negedge arst_n) begin
		logic  got;
		res_t  r;
		beat_t nb;
		if (!arst_n) begin
			feed_if.valid   <= 1'b0;
			feed_if.in_byte <= '0;
			feed_if.in_last <= 1'b0;
		end else begin
			if (feed_if.valid && feed_if.ready) begin
				text_step(feed_if.in_byte, feed_if.in_last, got, r);
				if (got)
					decoded_q.push_back(r);
			end
			if (!feed_if.valid || feed_if.ready) begin
				if (text_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nb = text_q.pop_front();
					feed_if.valid   <= 1'b1;
					feed_if.in_byte <= nb.b;
					feed_if.in_last <= nb.l;
				end else begin
					feed_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result beat: out_byte %02h out_last %0b status %0b",
						res_if.out_byte, res_if.out_last, res_if.status);
					n_fail = n_fail + 1;
				end else begin
					e = decoded_q.pop_front();
					if (res_if.out_byte !== e.data) begin
						$error("out_byte: expected %02h, actual %02h", e.data, res_if.out_byte);
						n_fail = n_fail + 1;
					end
					if (res_if.out_last !== e.last) begin
						$error("out_last: expected %0b, actual %0b", e.last, res_if.out_last);
						n_fail = n_fail + 1;
					end
					if (res_if.status !== e.status) begin
						$error("status: expected %0b, actual %0b", e.status, res_if.status);
						n_fail = n_fail + 1;
					end
				end
			end
			res_if.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	initial begin
		arst_n = 1'b0;

		// last byte at byte 0, last byte while seeking the newline
		push_beat(8'h41, 1'b1);
		push_beat(8'h41, 1'b0);
		push_beat(8'h42, 1'b1);
		// blanks incl. NUL, one byte 0xff completing on the last byte
		push_beat(8'hFF, 1'b0);
		push_beat(CHAR_NUL, 1'b0);
		push_str("\n");
		push_beat(CHAR_NUL, 1'b0);
		push_str(" \n1 f");
		push_beat(8'h66, 1'b1);
		// zero length, then drain to the last byte
		push_str("x\n0-");
		push_beat(8'h71, 1'b1);
		// data byte 0x00, then NUL in the hex data
		push_str("x\n2\n00");
		push_beat(CHAR_NUL, 1'b0);
		push_beat(8'h7A, 1'b1);
		// short text whose last byte would complete a data byte
		push_str("x\n3\n123");
		push_beat(8'h34, 1'b1);

		while (text_q.size() < N_ITEMS + 30)
			gen_text();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (text_q.size() != 0 || feed_if.valid);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (n_fail == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ raw_profile_hex_decoder.f @@
+incdir+hw/rtl
hw/rtl/rphd_pkg.sv
hw/rtl/rphd_in_if.sv
hw/rtl/rphd_out_if.sv
hw/rtl/rphd_front.sv
hw/rtl/rphd_queue.sv
hw/rtl/raw_profile_hex_decoder.sv
verif/tb_top.sv
